// File: hw/rtl/blf_pkg.sv
// ----------------------------------------------------------------------------
// blf_pkg
// Shared types and constants for the Blowfish block cipher core.
// ----------------------------------------------------------------------------
package blf_pkg;

    localparam int unsigned TABLE_WORDS = 1042;
    localparam int unsigned P_WORDS     = 18;
    localparam int unsigned S0_BASE     = 18;
    localparam int unsigned SBOX_WORDS  = 256;
    localparam int unsigned ROUNDS      = 16;

    localparam logic [4:0] P_LAST    = 5'd17;
    localparam logic [4:0] CNT_LAST  = 5'd16;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_BLOCK = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [10:0] table_index;
        logic [31:0] table_word;
        logic [63:0] data_block;
        logic        encrypt_mode;
        logic        last_block;
    } blf_in_t;

    typedef struct packed {
        logic [63:0] result_block;
        logic        result_last;
    } blf_out_t;

    typedef struct packed {
        logic [31:0] s0;
        logic [31:0] s1;
        logic [31:0] s2;
        logic [31:0] s3;
    } blf_sbox_words_t;

endpackage

// File: hw/rtl/blf_sbox_ram.sv
// ----------------------------------------------------------------------------
// blf_sbox_ram
// One 256 x 32 S-box: single write port, single registered read port.
// ----------------------------------------------------------------------------
module blf_sbox_ram
    import blf_pkg::*;
(
    input  logic        aclk,
    input  logic        wr_en,
    input  logic [7:0]  wr_addr,
    input  logic [31:0] wr_data,
    input  logic        rd_en,
    input  logic [7:0]  rd_addr,
    output logic [31:0] rd_data
);

    logic [31:0] mem [SBOX_WORDS];
    logic [31:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds when no read is issued
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/blf_feistel.sv
// ----------------------------------------------------------------------------
// blf_feistel
// Round function F: ((S0 + S1) ^ S2) + S3 on the four S-box read words.
// ----------------------------------------------------------------------------
module blf_feistel
    import blf_pkg::*;
(
    input  blf_sbox_words_t sbox,
    output logic [31:0]     f_val
);

    logic [31:0] sum01;

    always_comb begin
        sum01 = sbox.s0 + sbox.s1;
        f_val = (sum01 ^ sbox.s2) + sbox.s3;
    end

endmodule

// File: hw/rtl/blowfish_block_cipher_core_unit.sv
// ----------------------------------------------------------------------------
// blowfish_block_cipher_core_unit
// Blowfish ECB core, one 64-bit block per input beat, with loadable tables.
// ----------------------------------------------------------------------------
// Input beats on s_* carry either a key table word (kind 0) or a data block
// (kind 1). Load beats write P-array words 0..17 or S-box words 18..1041
// and give no result; indexes above 1041 are dropped. All 1042
// words must be loaded before any block is sent.
// A block beat runs in steps: the accept cycle applies the first P word
// and issues the first S-box reads, then 16 rounds run through one
// shared F unit (one round per cycle, limited by the registered read of the
// four S-box RAMs), then the final state applies the last P word and loads the
// output register. s_ready is low while a block is in flight.
// The result beat on m_* sits in an output register; a new beat may be
// accepted while it waits. If a finished block finds the previous result
// still waiting there, the core holds in its last cycle until that beat is
// taken.
// Reset (aresetn low, synchronous) returns to idle and drops any pending
// result; table contents are not cleared.
// ----------------------------------------------------------------------------
module blowfish_block_cipher_core_unit
    import blf_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  blf_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output blf_out_t m_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_FINAL = 2'd2;

    localparam logic [10:0] P_WORDS_W     = 11'(P_WORDS);
    localparam logic [10:0] S0_BASE_W     = 11'(S0_BASE);
    localparam logic [10:0] TABLE_WORDS_W = 11'(TABLE_WORDS);

    logic [1:0]  state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic        mode_reg, mode_next;
    logic        last_reg, last_next;
    logic        m_valid_reg, m_valid_next;
    blf_out_t    m_data_reg, m_data_next;

    logic [31:0] p_reg [P_WORDS];

    logic        in_acc, blk_acc, ld_acc;
    logic        mode_sel;
    logic [4:0]  p_idx;
    logic [31:0] p_word;
    logic [31:0] f_val;
    logic [31:0] new_b;
    logic [31:0] a0;
    logic [31:0] rd_word;
    logic        rd_en;
    logic        in_p, in_sbox;
    logic [10:0] sbox_off;
    logic [3:0]  sbox_we;
    logic        out_free;

    blf_sbox_words_t sbox_rd;

    // ---------------- input decode ----------------
    always_comb begin
        in_acc   = s_valid && s_ready;
        blk_acc  = in_acc && (s_data.kind == KIND_BLOCK);
        ld_acc   = in_acc && (s_data.kind == KIND_LOAD);
        in_p     = s_data.table_index < P_WORDS_W;
        in_sbox  = !in_p && (s_data.table_index < TABLE_WORDS_W);
        sbox_off = s_data.table_index - S0_BASE_W;
        for (int k = 0; k < 4; k++) begin
            sbox_we[k] = ld_acc && in_sbox && (sbox_off[9:8] == 2'(k));
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_acc && in_p) begin
            p_reg[s_data.table_index[4:0]] <= s_data.table_word;
        end
    end

    // ---------------- datapath ----------------
    // decrypt walks the P-array from the top down
    always_comb begin
        mode_sel = (state_reg == ST_IDLE) ? s_data.encrypt_mode : mode_reg;
        p_idx    = mode_sel ? cnt_reg : (P_LAST - cnt_reg);
        p_word   = p_reg[p_idx];
        new_b    = b_reg ^ p_word ^ f_val;
        a0       = s_data.data_block[63:32] ^ p_word;
        // address the S-boxes with the value that lands in a_reg next cycle
        rd_word  = (state_reg == ST_IDLE) ? a0 : new_b;
        rd_en    = blk_acc || (state_reg == ST_ROUND);
    end

    blf_sbox_ram u_sbox0 (
        .aclk    (aclk),
        .wr_en   (sbox_we[0]),
        .wr_addr (sbox_off[7:0]),
        .wr_data (s_data.table_word),
        .rd_en   (rd_en),
        .rd_addr (rd_word[31:24]),
        .rd_data (sbox_rd.s0)
    );

    blf_sbox_ram u_sbox1 (
        .aclk    (aclk),
        .wr_en   (sbox_we[1]),
        .wr_addr (sbox_off[7:0]),
        .wr_data (s_data.table_word),
        .rd_en   (rd_en),
        .rd_addr (rd_word[23:16]),
        .rd_data (sbox_rd.s1)
    );

    blf_sbox_ram u_sbox2 (
        .aclk    (aclk),
        .wr_en   (sbox_we[2]),
        .wr_addr (sbox_off[7:0]),
        .wr_data (s_data.table_word),
        .rd_en   (rd_en),
        .rd_addr (rd_word[15:8]),
        .rd_data (sbox_rd.s2)
    );

    blf_sbox_ram u_sbox3 (
        .aclk    (aclk),
        .wr_en   (sbox_we[3]),
        .wr_addr (sbox_off[7:0]),
        .wr_data (s_data.table_word),
        .rd_en   (rd_en),
        .rd_addr (rd_word[7:0]),
        .rd_data (sbox_rd.s3)
    );

    blf_feistel u_feistel (
        .sbox  (sbox_rd),
        .f_val (f_val)
    );

    // ---------------- sequencer ----------------
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        mode_next    = mode_reg;
        last_next    = last_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        out_free     = !m_valid_reg || m_ready;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (blk_acc) begin
                    a_next     = a0;
                    b_next     = s_data.data_block[31:0];
                    mode_next  = s_data.encrypt_mode;
                    last_next  = s_data.last_block;
                    cnt_next   = 5'd1;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                // halves swap every round; a_reg always feeds F
                a_next   = new_b;
                b_next   = a_reg;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    m_data_next.result_block = {b_reg ^ p_word, a_reg};
                    m_data_next.result_last  = last_reg;
                    m_valid_next             = 1'b1;
                    cnt_next                 = 5'd0;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                cnt_next   = 5'd0;
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= 5'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        mode_reg   <= mode_next;
        last_reg   <= last_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
